// ===== sv/tbmr_pkg.sv =====
// Shared types and constants for the time-binned metric ring.
package tbmr_pkg;

  localparam int ROWS_DEFAULT    = 64;
  localparam int COLUMNS_DEFAULT = 8;

  localparam int TS_W   = 32;  // timestamp width
  localparam int BIN_W  = 20;  // bin_seconds width
  localparam int MODE_W = 16;  // column_modes width
  localparam int VAL_W  = 32;  // cell value width
  localparam int COL_W  = 3;   // column_index width
  localparam int OP_W   = 2;   // operation width

  // Register index, taken from paddr[2]
  localparam logic REG_BIN_SECONDS  = 1'b0;
  localparam logic REG_COLUMN_MODES = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SET = 2'd1,
    OP_GET = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_SUM  = 2'd0,
    MODE_MIN  = 2'd1,
    MODE_MAX  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_CLEAR,
    ST_READ,
    ST_MODIFY,
    ST_OUT
  } state_e;

  // Store port controls
  typedef struct packed {
    logic rd_en;
    logic occ_we;
    logic cell_we;
  } store_ctl_t;

endpackage

// ===== sv/time_binned_metric_ring.sv =====
// Top level of the time-binned metric ring: stream ports, APB registers, control.
//
// A ring of ROWS time bins by COLUMNS signed 32-bit cells. Each input word
// carries an operation (add, set, get) in tuser and a timestamp, column and
// value in tdata; each input word yields exactly one output word with the
// in-window flag, the has-value flag and the cell contents after the
// operation (zero when empty or outside the window). The timestamp is divided
// by bin_seconds in a bit-serial divider (one quotient bit per cycle),
// which sets most of the per-item time. An in-window item then passes
// the window check, a memory read and the modify step into the output
// register; a nil answer goes there from the check with no memory access.
// An add or set that moves to a newer bin first clears the skipped rows
// (up to ROWS). Items are processed one at a time: the next word is taken
// once the previous result sits in the output register, even if the sink
// has not taken it. Cell values and occupancy live in block memories read
// per in-window item and written back on add and set. After reset a
// clearing pass over all ROWS rows empties the occupancy memory; no input
// is taken during it, but register writes are. Registers: bin_seconds at
// 0x0 (0 behaves as 1), column_modes at 0x4 (2 bits per column: sum, min,
// max, none). Sums saturate to the signed 32-bit range.
module time_binned_metric_ring import tbmr_pkg::*; #(
  parameter int ROWS    = ROWS_DEFAULT,
  parameter int COLUMNS = COLUMNS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // timestamp_seconds[31:0], column_index[34:32],
                                      // sample_value[66:35], zero fill
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cell_value[31:0]
  output logic [1:0]  m_axis_tuser,   // in_window[0], has_value[1]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW   = $clog2(ROWS);
  localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CNTW = $clog2(ROWS + 1);

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // ---------------------------------------------------------------- registers
  logic [BIN_W-1:0]  bin_seconds_q;
  logic [MODE_W-1:0] column_modes_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_seconds_q  <= BIN_W'(60);
      column_modes_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_BIN_SECONDS:  bin_seconds_q  <= pwdata[BIN_W-1:0];
        REG_COLUMN_MODES: column_modes_q <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BIN_SECONDS:  prdata = {{(32-BIN_W){1'b0}}, bin_seconds_q};
      REG_COLUMN_MODES: prdata = {{(32-MODE_W){1'b0}}, column_modes_q};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  state_e state_q, state_d;

  logic [OP_W-1:0]  op_q;
  logic [COL_W-1:0] col_q;
  logic [VAL_W-1:0] val_q;

  logic [TS_W-1:0]  bin_q;
  logic [RW-1:0]    slot_q;
  logic [TS_W-1:0]  newest_bin_q;
  logic [RW-1:0]    newest_slot_q;
  logic [RW-1:0]    ptr_q;     // row pointer for clearing
  logic [CNTW-1:0]  cnt_q;     // rows left to clear

  logic             res_win_q;
  logic             res_has_q;
  logic [VAL_W-1:0] res_val_q;

  logic             m_valid_q;
  logic [1:0]       m_user_q;
  logic [VAL_W-1:0] m_data_q;
  logic             out_load;  // result moves into the output register

  // ---------------------------------------------------------------- divider
  logic             div_start;
  logic             div_done;
  logic [TS_W-1:0]  div_quot;
  logic [RW-1:0]    div_slot;
  logic [BIN_W-1:0] divisor;

  assign divisor = (bin_seconds_q == '0) ? BIN_W'(1) : bin_seconds_q;

  tbmr_div #(
    .ROWS (ROWS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata[TS_W-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .slot_o     (div_slot)
  );

  // ---------------------------------------------------------------- store
  store_ctl_t        store_ctl;
  logic [RW-1:0]     store_row;
  logic [COLUMNS-1:0] occ_wdata;
  logic [VAL_W-1:0]  cell_wdata;
  logic [COLUMNS-1:0] occ_rdata;
  logic [VAL_W-1:0]  cell_rdata;
  logic [CW-1:0]     col_idx;

  assign col_idx = col_q[CW-1:0];

  tbmr_store #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (store_ctl),
    .row_i        (store_row),
    .col_i        (col_idx),
    .occ_wdata_i  (occ_wdata),
    .cell_wdata_i (cell_wdata),
    .occ_rdata_o  (occ_rdata),
    .cell_rdata_o (cell_rdata)
  );

  // ---------------------------------------------------------------- window check
  logic [TS_W:0]   delta;       // bin - newest_bin, sign in top bit
  logic            newer;
  logic            too_old;
  logic            writes;
  logic            col_bad;
  logic [CNTW-1:0] skip_rows;
  logic [RW-1:0]   slot_next;   // newest_slot + 1, wrapped
  logic [RW-1:0]   ptr_next;

  assign delta   = {1'b0, bin_q} - {1'b0, newest_bin_q};
  assign newer   = !delta[TS_W] && (delta != '0);
  assign too_old = $signed(delta) <= $signed((TS_W+1)'(0) - (TS_W+1)'(ROWS));
  assign writes  = (op_q == OP_ADD) || (op_q == OP_SET);
  assign col_bad = ({1'b0, col_q} >= (COL_W+1)'(COLUMNS));
  assign skip_rows = (delta[TS_W-1:0] >= TS_W'(ROWS)) ? CNTW'(ROWS)
                                                      : delta[CNTW-1:0];
  assign slot_next = (newest_slot_q == RW'(ROWS-1)) ? '0 : newest_slot_q + 1'b1;
  assign ptr_next  = (ptr_q == RW'(ROWS-1)) ? '0 : ptr_q + 1'b1;

  // ---------------------------------------------------------------- modify
  logic [COLUMNS-1:0] col_mask;
  logic               occ_hit;
  mode_e              col_mode;
  logic [VAL_W:0]     sum_ext;
  logic [VAL_W-1:0]   sum_sat;
  logic [VAL_W-1:0]   new_val;

  assign col_mask = COLUMNS'(1) << col_idx;
  assign occ_hit  = |(occ_rdata & col_mask);
  assign col_mode = mode_e'(column_modes_q[{col_q, 1'b0} +: 2]);
  assign sum_ext  = {val_q[VAL_W-1], val_q} + {cell_rdata[VAL_W-1], cell_rdata};

  always_comb begin
    // overflow when the two top bits of the extended sum disagree
    if (sum_ext[VAL_W] != sum_ext[VAL_W-1]) begin
      sum_sat = sum_ext[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sum_sat = sum_ext[VAL_W-1:0];
    end
  end

  always_comb begin
    new_val = cell_rdata;
    case (op_q)
      OP_ADD: new_val = occ_hit ? sum_sat : val_q;
      OP_SET: begin
        case (col_mode)
          MODE_MIN: new_val = (!occ_hit || ($signed(val_q) < $signed(cell_rdata)))
                              ? val_q : cell_rdata;
          MODE_MAX: new_val = (!occ_hit || ($signed(val_q) > $signed(cell_rdata)))
                              ? val_q : cell_rdata;
          default:  new_val = val_q;
        endcase
      end
      default: new_val = cell_rdata;   // get, and the unused code
    endcase
  end

  // output register takes a new result when empty or draining this cycle
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:   if (ptr_q == RW'(ROWS-1)) state_d = ST_IDLE;
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_CHECK;
      ST_CHECK: begin
        if (newer && writes) begin
          state_d = ST_CLEAR;
        end else if (newer || too_old || col_bad) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_CLEAR:  if (cnt_q == CNTW'(1)) state_d = col_bad ? ST_OUT : ST_READ;
      ST_READ:   state_d = ST_MODIFY;
      ST_MODIFY: state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    store_ctl     = '0;
    store_row     = slot_q;
    occ_wdata     = '0;
    cell_wdata    = new_val;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        store_ctl.occ_we = 1'b1;
        store_row        = ptr_q;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = s_axis_tvalid;
      end
      ST_READ: begin
        store_ctl.rd_en = 1'b1;
      end
      ST_MODIFY: begin
        store_ctl.occ_we  = writes;
        store_ctl.cell_we = writes;
        occ_wdata         = occ_rdata | col_mask;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      op_q          <= '0;
      col_q         <= '0;
      val_q         <= '0;
      bin_q         <= '0;
      slot_q        <= '0;
      newest_bin_q  <= TS_W'(ROWS - 1);
      newest_slot_q <= RW'(ROWS - 1);
      ptr_q         <= '0;
      cnt_q         <= '0;
      res_win_q     <= 1'b0;
      res_has_q     <= 1'b0;
      res_val_q     <= '0;
      m_valid_q     <= 1'b0;
      m_user_q      <= '0;
      m_data_q      <= '0;
    end else begin
      state_q <= state_d;

      if (out_load) begin
        m_valid_q <= 1'b1;
        m_user_q  <= {res_has_q, res_win_q};
        m_data_q  <= res_val_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_INIT: begin
          ptr_q <= ptr_next;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q  <= s_axis_tuser;
            col_q <= s_axis_tdata[TS_W+COL_W-1:TS_W];
            val_q <= s_axis_tdata[TS_W+COL_W+VAL_W-1:TS_W+COL_W];
          end
        end
        ST_DIV: begin
          if (div_done) begin
            bin_q  <= div_quot;
            slot_q <= div_slot;
          end
        end
        ST_CHECK: begin
          res_win_q <= 1'b0;
          res_has_q <= 1'b0;
          res_val_q <= '0;
          if (newer && writes) begin
            // advance: clear the skipped rows after the old newest row
            cnt_q         <= skip_rows;
            ptr_q         <= slot_next;
            newest_bin_q  <= bin_q;
            newest_slot_q <= slot_q;
          end
        end
        ST_CLEAR: begin
          ptr_q <= ptr_next;
          cnt_q <= cnt_q - 1'b1;
        end
        ST_MODIFY: begin
          res_win_q <= 1'b1;
          res_has_q <= writes || occ_hit;
          res_val_q <= (writes || occ_hit) ? new_val : '0;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== sv/tbmr_div.sv =====
// Bit-serial timestamp divider that also reduces the quotient modulo ROWS.
module tbmr_div import tbmr_pkg::*; #(
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [TS_W-1:0]          dividend_i,
  input  logic [BIN_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic [TS_W-1:0]          quotient_o,
  output logic [$clog2(ROWS)-1:0]  slot_o
);

  localparam int SW    = $clog2(ROWS);
  localparam int STEPW = $clog2(TS_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [STEPW-1:0] step_q, step_d;
  logic [TS_W-1:0]  num_q, num_d;
  logic [BIN_W-1:0] rem_q, rem_d;
  logic [BIN_W-1:0] div_q, div_d;
  logic [SW-1:0]    slot_q, slot_d;

  logic [BIN_W:0]   rem_sh;
  logic             ge;
  logic [SW:0]      slot_sh;

  // one quotient bit per cycle while busy, MSB first; slot follows as a running mod
  always_comb begin
    rem_sh  = {rem_q, num_q[TS_W-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    slot_sh = {slot_q, ge};

    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    slot_d = slot_q;

    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      slot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? BIN_W'(rem_sh - {1'b0, div_q}) : rem_sh[BIN_W-1:0];
      num_d  = {num_q[TS_W-2:0], ge};
      slot_d = (slot_sh >= (SW+1)'(ROWS)) ? SW'(slot_sh - (SW+1)'(ROWS)) : slot_sh[SW-1:0];
      step_d = step_q + 1'b1;
      if (step_q == STEPW'(TS_W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      slot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      num_q  <= num_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
      slot_q <= slot_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;
  assign slot_o     = slot_q;

endmodule

// ===== sv/tbmr_store.sv =====
// Cell value memory and per-row occupancy memory, with registered read data.
module tbmr_store import tbmr_pkg::*; #(
  parameter int ROWS    = ROWS_DEFAULT,
  parameter int COLUMNS = COLUMNS_DEFAULT
) (
  input  logic                                     clk_i,
  input  store_ctl_t                               ctl_i,
  input  logic [$clog2(ROWS)-1:0]                  row_i,
  input  logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] col_i,
  input  logic [COLUMNS-1:0]                       occ_wdata_i,
  input  logic [VAL_W-1:0]                         cell_wdata_i,
  output logic [COLUMNS-1:0]                       occ_rdata_o,
  output logic [VAL_W-1:0]                         cell_rdata_o
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CELLS = ROWS * (1 << CW);

  logic [COLUMNS-1:0] occ_mem  [ROWS];
  logic [VAL_W-1:0]   cell_mem [CELLS];

  logic [COLUMNS-1:0] occ_rdata_q;
  logic [VAL_W-1:0]   cell_rdata_q;
  logic [RW+CW-1:0]   cell_addr;

  assign cell_addr = {row_i, col_i};

  always_ff @(posedge clk_i) begin
    if (ctl_i.occ_we) begin
      occ_mem[row_i] <= occ_wdata_i;
    end
    if (ctl_i.rd_en) begin
      occ_rdata_q <= occ_mem[row_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cell_we) begin
      cell_mem[cell_addr] <= cell_wdata_i;
    end
    if (ctl_i.rd_en) begin
      cell_rdata_q <= cell_mem[cell_addr];
    end
  end

  assign occ_rdata_o  = occ_rdata_q;
  assign cell_rdata_o = cell_rdata_q;

endmodule

// ===== verif/tb_time_binned_metric_ring.sv =====
// Testbench for the time-binned metric ring: directed table, random phases, predictor check.
`timescale 1ns / 1ps

module tb_time_binned_metric_ring import tbmr_pkg::*;;

  localparam int RING_ROWS    = ROWS_DEFAULT;
  localparam int RING_COLUMNS = COLUMNS_DEFAULT;
  localparam int RING_CELLS   = RING_ROWS * RING_COLUMNS;

  // Operation code 3 is not in op_e; the block treats it as a get.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  // Bin of the all-ones timestamp at 60 s per bin; used as a seconds value at width 1.
  localparam logic [31:0] TS_FAR  = 32'h0444_4444;

  localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on any port
  localparam int ERROR_PRINTS  = 200;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 125;
  localparam int DIRECTED_ROWS = 27;

  typedef struct packed {
    logic        in_window;
    logic        has_value;
    logic [31:0] cell_value;
  } ring_result_t;

  // One directed word, with the register settings it needs and, where obvious,
  // the expected result typed in.
  typedef struct packed {
    logic [19:0]  cfg_bin;
    logic [15:0]  cfg_modes;
    logic [1:0]   op;
    logic [31:0]  ts;
    logic [2:0]   col;
    logic [31:0]  value;
    logic         typed;
    ring_result_t want;
  } directed_row_t;

  localparam ring_result_t NIL = '{1'b0, 1'b0, 32'd0};

  directed_row_t directed_plan [DIRECTED_ROWS] = '{
    // reset settings: 60 s bins, all columns sum; bins 0..63 in window
    '{20'd60, 16'h0, OP_GET, 32'd0, 3'd0, 32'd0, 1'b1, '{1'b1, 1'b0, 32'd0}},
    '{20'd60, 16'h0, OP_ADD, 32'd0, 3'd0, VAL_MAX, 1'b1, '{1'b1, 1'b1, VAL_MAX}},
    '{20'd60, 16'h0, OP_ADD, 32'd59, 3'd0, 32'd1, 1'b1, '{1'b1, 1'b1, VAL_MAX}},
    '{20'd60, 16'h0, OP_ADD, 32'd0, 3'd7, VAL_MIN, 1'b1, '{1'b1, 1'b1, VAL_MIN}},
    '{20'd60, 16'h0, OP_ADD, 32'd0, 3'd7, -32'sd1, 1'b1, '{1'b1, 1'b1, VAL_MIN}},
    '{20'd60, 16'h0, OP_GET, 32'd3839, 3'd7, 32'd0, 1'b1, '{1'b1, 1'b0, 32'd0}},
    // get on a newer bin answers nil and does not move the ring
    '{20'd60, 16'h0, OP_GET, 32'd3840, 3'd7, 32'd0, 1'b1, NIL},
    '{20'd60, 16'h0, OP_UNUSED, 32'd0, 3'd0, 32'd0, 1'b1, '{1'b1, 1'b1, VAL_MAX}},
    // set one bin ahead: ring advances one row, bin 0 drops out
    '{20'd60, 16'h0, OP_SET, 32'd3840, 3'd7, 32'd5, 1'b1, '{1'b1, 1'b1, 32'd5}},
    '{20'd60, 16'h0, OP_GET, 32'd0, 3'd0, 32'd0, 1'b1, NIL},
    '{20'd60, 16'h0, OP_ADD, 32'd119, 3'd7, 32'd3, 1'b1, '{1'b1, 1'b1, 32'd3}},
    // widest bin, jump far past the ring: everything cleared
    '{20'hFFFFF, 16'h0, OP_ADD, 32'hFFFF_FFFF, 3'd3, 32'd7, 1'b1, '{1'b1, 1'b1, 32'd7}},
    '{20'hFFFFF, 16'h0, OP_GET, 32'd0, 3'd3, 32'd0, 1'b1, NIL},
    '{20'd60, 16'h0, OP_ADD, 32'hFFFF_FFFF, 3'd3, -32'sd7, 1'b1, '{1'b1, 1'b1, -32'sd7}},
    '{20'd60, 16'h0, OP_GET, 32'd0, 3'd3, 32'd0, 1'b1, NIL},
    // 1 s bins; column 0 min, 1 max, 2 none, 3 sum; newest bin keeps its number
    '{20'd1, 16'h3939, OP_SET, TS_FAR, 3'd0, 32'd10, 1'b1, '{1'b1, 1'b1, 32'd10}},
    '{20'd1, 16'h3939, OP_SET, TS_FAR, 3'd0, 32'd20, 1'b0, NIL},
    '{20'd1, 16'h3939, OP_SET, TS_FAR, 3'd0, -32'sd3, 1'b0, NIL},
    '{20'd1, 16'h3939, OP_SET, TS_FAR, 3'd1, 32'd10, 1'b1, '{1'b1, 1'b1, 32'd10}},
    '{20'd1, 16'h3939, OP_SET, TS_FAR, 3'd1, 32'd4, 1'b0, NIL},
    '{20'd1, 16'h3939, OP_SET, TS_FAR, 3'd1, 32'd99, 1'b0, NIL},
    '{20'd1, 16'h3939, OP_SET, TS_FAR, 3'd2, -32'sd8, 1'b1, '{1'b1, 1'b1, -32'sd8}},
    '{20'd1, 16'h3939, OP_SET, TS_FAR, 3'd2, 32'd8, 1'b0, NIL},
    // add ignores the column mode
    '{20'd1, 16'h3939, OP_ADD, TS_FAR, 3'd0, 32'd5, 1'b0, NIL},
    // zero width behaves as one second; all columns none
    '{20'd0, 16'hFFFF, OP_GET, TS_FAR, 3'd0, 32'd0, 1'b0, NIL},
    '{20'd0, 16'hFFFF, OP_SET, TS_FAR, 3'd0, -32'sd100, 1'b1, '{1'b1, 1'b1, -32'sd100}},
    '{20'd0, 16'hFFFF, OP_SET, TS_FAR + 32'd1, 3'd5, 32'd0, 1'b1, '{1'b1, 1'b1, 32'd0}}
  };

  localparam logic [19:0] PHASE_BIN   [PHASES] = '{20'd1, 20'd0, 20'd17, 20'd3, 20'd30, 20'd1};
  localparam logic [15:0] PHASE_MODES [PHASES] = '{16'hFFFF, 16'h0000, 16'h1B1B, 16'hE4E4,
                                                   16'h0, 16'h0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // timestamp[31:0], column[34:32], value[66:35], zero fill
  logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // cell_value[31:0]
  logic [1:0]  m_axis_tuser;        // in_window[0], has_value[1]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: a mirror of the ring and its registers.
  logic [19:0]        ring_bin_seconds = 20'd60;
  logic [15:0]        ring_column_modes = 16'd0;
  logic signed [31:0] ring_cells [RING_CELLS];
  bit                 ring_occupied [RING_CELLS];
  longint             ring_newest_bin = RING_ROWS - 1;
  int                 ring_newest_row = RING_ROWS - 1;

  ring_result_t expected_results [$];
  int           error_count = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           sink_idle_pct = 0;

  time_binned_metric_ring uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Bins a word, moves the ring on a newer add or set, applies the operation
  // and returns what the block should answer.
  function automatic ring_result_t predict_ring_item(input logic [1:0] op,
                                                     input logic [31:0] ts,
                                                     input logic [2:0] col,
                                                     input logic signed [31:0] value);
    ring_result_t res;
    longint unsigned width;
    longint bin, delta, span, sum, k;
    int slot, idx, c;
    bit writes, empty;
    mode_e mode;
    res = NIL;
    width = (ring_bin_seconds == 0) ? 1 : longint'(ring_bin_seconds);
    bin = longint'(longint'({32'd0, ts}) / width);
    delta = bin - ring_newest_bin;
    writes = (op == OP_ADD) || (op == OP_SET);
    if (delta > 0 && writes) begin
      span = (delta > RING_ROWS) ? RING_ROWS : delta;
      for (k = 1; k <= span; k++) begin
        slot = int'((ring_newest_row + k) % RING_ROWS);
        for (c = 0; c < RING_COLUMNS; c++) ring_occupied[slot * RING_COLUMNS + c] = 1'b0;
      end
      ring_newest_bin = bin;
      ring_newest_row = int'(bin % RING_ROWS);
    end else if (delta > 0 || delta <= -RING_ROWS) begin
      return res;
    end
    if (col >= RING_COLUMNS) return res;

    idx = int'(bin % RING_ROWS) * RING_COLUMNS + col;
    empty = !ring_occupied[idx];
    if (op == OP_ADD) begin
      if (empty) begin
        ring_cells[idx] = value;
      end else begin
        sum = longint'(ring_cells[idx]) + longint'(value);
        if (sum > 64'sh7FFF_FFFF) ring_cells[idx] = VAL_MAX;
        else if (sum < -64'sh8000_0000) ring_cells[idx] = VAL_MIN;
        else ring_cells[idx] = sum[31:0];
      end
      ring_occupied[idx] = 1'b1;
    end else if (op == OP_SET) begin
      mode = mode_e'(ring_column_modes[2 * col +: 2]);
      case (mode)
        MODE_MIN: begin
          if (empty || value < ring_cells[idx]) ring_cells[idx] = value;
        end
        MODE_MAX: begin
          if (empty || value > ring_cells[idx]) ring_cells[idx] = value;
        end
        default: ring_cells[idx] = value;
      endcase
      ring_occupied[idx] = 1'b1;
    end
    res.in_window = 1'b1;
    if (ring_occupied[idx]) begin
      res.has_value  = 1'b1;
      res.cell_value = ring_cells[idx];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= ERROR_PRINTS)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Offers one word after a random gap, and queues its expected result once
  // the block takes it.
  task automatic send_sample(input logic [1:0] op, input logic [31:0] ts,
                             input logic [2:0] col, input logic [31:0] value,
                             input logic typed, input ring_result_t want);
    ring_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, value, col, ts};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_ring_item(op, ts, col, value);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_register(input logic reg_idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (reg_idx == REG_BIN_SECONDS) ? 32'h000F_FFFF : 32'h0000_FFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_idx == REG_BIN_SECONDS) ring_bin_seconds = value[19:0];
    else ring_column_modes = value[15:0];

    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    report_mismatch(reg_idx == REG_BIN_SECONDS ? "bin_seconds readback" : "column_modes readback",
                    value & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only with the ring idle: stop offering and drain first.
  task automatic settle_and_configure(input logic [19:0] bin_s, input logic [15:0] modes);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    write_register(REG_BIN_SECONDS, {12'd0, bin_s});
    write_register(REG_COLUMN_MODES, {16'd0, modes});
  endtask

  // Random word aimed mostly at the live window around the newest bin, with
  // some row-skipping jumps and a little noise at arbitrary timestamps.
  task automatic random_sample();
    longint unsigned width, stamp;
    longint bin;
    int pick;
    logic [1:0] op;
    logic [31:0] ts, value;
    logic [2:0] col;
    width = (ring_bin_seconds == 0) ? 1 : longint'(ring_bin_seconds);
    pick = $urandom_range(0, 99);
    col = 3'($urandom_range(0, 7));

    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: value = 32'($urandom_range(0, 200)) - 32'd100;
      6, 7:             value = VAL_MAX - 32'($urandom_range(0, 50));
      8:                value = VAL_MIN + 32'($urandom_range(0, 50));
      default:          value = $urandom;
    endcase

    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_ADD;
    else if (pick < 75) op = OP_SET;
    else if (pick < 93) op = OP_GET;
    else op = OP_UNUSED;

    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // noise: any timestamp, read-only so the ring is not flung forward
      ts = $urandom;
      op = (pick < 3) ? OP_GET : OP_UNUSED;
    end else begin
      if (pick < 70) bin = ring_newest_bin - $urandom_range(0, 66);
      else if (pick < 92) bin = ring_newest_bin + $urandom_range(1, 3);
      else if (pick < 97) bin = ring_newest_bin + $urandom_range(62, 70);
      else bin = ring_newest_bin + $urandom_range(71, 3000);
      if (bin < 0) bin = 0;
      stamp = longint'(bin) * width + $urandom_range(0, 32'(width - 1));
      if (stamp > 64'hFFFF_FFFF) stamp = longint'(ring_newest_bin) * width;
      ts = stamp[31:0];
    end
    send_sample(op, ts, col, value, 1'b0, NIL);
  endtask

  // Output side: random ready, in-order compare, and the stall watchdog.
  always @(posedge clk_i) begin : result_check
    ring_result_t got;
    ring_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= ERROR_PRINTS)
          $display("%0t: unexpected word: expected none, actual %0b %0b %0h", $time,
                   got.in_window, got.has_value, got.cell_value);
      end else begin
        want = expected_results.pop_front();
        report_mismatch("in_window", 32'(want.in_window), 32'(got.in_window));
        report_mismatch("has_value", 32'(want.has_value), 32'(got.has_value));
        report_mismatch("cell_value", want.cell_value, got.cell_value);
      end
    end

    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;

    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_time_binned_metric_ring: FAIL");
      $finish;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  initial begin : stimulus
    int p, i;
    foreach (ring_cells[n]) ring_cells[n] = '0;
    foreach (ring_occupied[n]) ring_occupied[n] = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 10;
    sink_idle_pct = 70;
    foreach (directed_plan[r]) begin
      if (directed_plan[r].cfg_bin != ring_bin_seconds ||
          directed_plan[r].cfg_modes != ring_column_modes)
        settle_and_configure(directed_plan[r].cfg_bin, directed_plan[r].cfg_modes);
      send_sample(directed_plan[r].op, directed_plan[r].ts, directed_plan[r].col,
                  directed_plan[r].value, directed_plan[r].typed, directed_plan[r].want);
    end

    // Bin widths stay small so the newest bin can keep moving forward.
    for (p = 0; p < PHASES; p++) begin
      settle_and_configure(PHASE_BIN[p], (p >= 4) ? 16'($urandom) : PHASE_MODES[p]);
      case (p / 2)
        0: begin
          send_idle_pct = 10;
          sink_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          sink_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (i = 0; i < PHASE_WORDS; i++) random_sample();
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0)
      $display("tb_time_binned_metric_ring: PASS");
    else
      $display("tb_time_binned_metric_ring: FAIL");
    $finish;
  end

endmodule
